FILE: hdl/gbka_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbka_pkg
// Shared types and constants for the group-by-key average block.
// ----------------------------------------------------------------------------
package gbka_pkg;
    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int DIV_W   = 32;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_FULL   = 3'd1,
        ST_SAT    = 3'd2,
        ST_AVG    = 3'd3,
        ST_NODATA = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DIV,
        S_OUT,
        S_DONE
    } fsm_t;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;
endpackage

FILE: hdl/group_by_key_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_by_key_average
// Per tag and key running sum and count table with averaged reports.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// s_      | in        | s_valid s_ready s_operation s_tag_id s_num_key s_sample_time
// m_      | out       | m_valid m_ready m_status m_key_out m_avg_time m_last
//
// One word at a time. A sample scans the table from a table memory with one
// read port and one write port. Each entry passes through a read state and a
// compare state. A report scans the same way. It runs a 48-step restoring
// divider for each matching group. Each average waits until the next match or
// the end of the scan sets its last flag. A full output register stalls the
// scan at the next word. Reset clears the fill count and the control state.
// The table contents need no reset.
// ----------------------------------------------------------------------------
module group_by_key_average (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_tag_id,
    input  logic [31:0] s_num_key,
    input  logic [31:0] s_sample_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_key_out,
    output logic [31:0] m_avg_time,
    output logic        m_last
);
    localparam int IW = gbka_pkg::IDX_W;
    localparam int FW = gbka_pkg::FILL_W;
    localparam int SW = gbka_pkg::SUM_W;
    localparam int CW = gbka_pkg::CNT_W;
    localparam int DW = gbka_pkg::DIV_W;
    localparam int KW = gbka_pkg::DCNT_W;
    localparam int EW = 8 + 32 + SW + CW;

    logic [EW-1:0] mem [gbka_pkg::ENTRIES];
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    gbka_pkg::fsm_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic          op_reg, op_next;
    logic [7:0]    tag_reg, tag_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   time_reg, time_next;
    logic          found_reg, found_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] num_reg, num_next;
    logic [CW-1:0] den_reg, den_next;
    logic [KW-1:0] dcnt_reg, dcnt_next;
    logic [31:0]   gkey_reg, gkey_next;
    logic          mv_reg, mv_next;
    logic [2:0]    ms_reg, ms_next;
    logic [31:0]   mk_reg, mk_next;
    logic [31:0]   ma_reg, ma_next;
    logic          ml_reg, ml_next;

    logic [7:0]    e_tag;
    logic [31:0]   e_key;
    logic [SW-1:0] e_sum;
    logic [CW-1:0] e_cnt;
    logic          out_free;
    logic [SW:0]   trial;
    logic [SW-1:0] shifted;
    logic          next_more;

    assign {e_tag, e_key, e_sum, e_cnt} = rd_data;
    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == gbka_pkg::S_IDLE);
    assign next_more = (idx_reg + FW'(1)) < fill_reg;
    assign shifted   = {rem_reg[SW-2:0], num_reg[SW-1]};
    assign trial     = {1'b0, shifted} - {{(SW - CW + 1){1'b0}}, den_reg};

    assign m_valid    = mv_reg;
    assign m_status   = ms_reg;
    assign m_key_out  = mk_reg;
    assign m_avg_time = ma_reg;
    assign m_last     = ml_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbka_pkg::S_IDLE;
            fill_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
        end
        idx_reg   <= idx_next;
        op_reg    <= op_next;
        tag_reg   <= tag_next;
        key_reg   <= key_next;
        time_reg  <= time_next;
        found_reg <= found_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        dcnt_reg  <= dcnt_next;
        gkey_reg  <= gkey_next;
        ms_reg    <= ms_next;
        mk_reg    <= mk_next;
        ma_reg    <= ma_next;
        ml_reg    <= ml_next;
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        tag_next   = tag_reg;
        key_next   = key_reg;
        time_next  = time_reg;
        found_next = found_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        dcnt_next  = dcnt_reg;
        gkey_next  = gkey_reg;
        mv_next    = mv_reg && !m_ready;
        ms_next    = ms_reg;
        mk_next    = mk_reg;
        ma_next    = ma_reg;
        ml_next    = ml_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IW-1:0];
        wr_data    = rd_data;
        rd_addr    = idx_reg[IW-1:0];

        unique case (state_reg)
            gbka_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    tag_next   = s_tag_id;
                    key_next   = s_num_key;
                    time_next  = s_sample_time;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (fill_reg == '0) ? gbka_pkg::S_DONE : gbka_pkg::S_READ;
                end
            end
            gbka_pkg::S_READ: begin
                state_next = gbka_pkg::S_CHECK;
            end
            gbka_pkg::S_CHECK: begin
                if (op_reg == gbka_pkg::OP_ADD) begin
                    if (e_tag == tag_reg && e_key == key_reg) begin
                        if (out_free) begin
                            mv_next = 1'b1;
                            mk_next = '0;
                            ma_next = '0;
                            ml_next = 1'b1;
                            if (e_cnt == '1) begin
                                ms_next = gbka_pkg::ST_SAT;
                            end else begin
                                ms_next = gbka_pkg::ST_ADDED;
                                wr_en   = 1'b1;
                                wr_data = {e_tag, e_key, e_sum + SW'(time_reg),
                                           e_cnt + CW'(1)};
                            end
                            state_next = gbka_pkg::S_IDLE;
                        end
                    end else if (next_more) begin
                        idx_next   = idx_reg + FW'(1);
                        state_next = gbka_pkg::S_READ;
                    end else begin
                        idx_next   = fill_reg;
                        state_next = gbka_pkg::S_DONE;
                    end
                end else begin
                    if (e_tag == tag_reg) begin
                        // earlier average goes out now, it is not the last
                        if (!found_reg || out_free) begin
                            if (found_reg) begin
                                mv_next = 1'b1;
                                ms_next = gbka_pkg::ST_AVG;
                                mk_next = gkey_reg;
                                ma_next = quo_reg;
                                ml_next = 1'b0;
                            end
                            found_next = 1'b1;
                            gkey_next  = e_key;
                            num_next   = e_sum;
                            den_next   = e_cnt;
                            rem_next   = '0;
                            quo_next   = '0;
                            dcnt_next  = KW'(SW);
                            state_next = gbka_pkg::S_DIV;
                        end
                    end else if (next_more) begin
                        idx_next   = idx_reg + FW'(1);
                        state_next = gbka_pkg::S_READ;
                    end else begin
                        state_next = gbka_pkg::S_DONE;
                    end
                end
            end
            gbka_pkg::S_DIV: begin
                num_next  = {num_reg[SW-2:0], 1'b0};
                dcnt_next = dcnt_reg - KW'(1);
                if (!trial[SW]) begin
                    rem_next = trial[SW-1:0];
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                if (dcnt_reg == KW'(1)) begin
                    state_next = gbka_pkg::S_OUT;
                end
            end
            gbka_pkg::S_OUT: begin
                if (next_more) begin
                    idx_next   = idx_reg + FW'(1);
                    state_next = gbka_pkg::S_READ;
                end else begin
                    idx_next   = fill_reg;
                    state_next = gbka_pkg::S_DONE;
                end
            end
            gbka_pkg::S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = '0;
                    ma_next    = '0;
                    ml_next    = 1'b1;
                    state_next = gbka_pkg::S_IDLE;
                    if (op_reg == gbka_pkg::OP_REPORT) begin
                        if (found_reg) begin
                            ms_next = gbka_pkg::ST_AVG;
                            mk_next = gkey_reg;
                            ma_next = quo_reg;
                        end else begin
                            ms_next = gbka_pkg::ST_NODATA;
                        end
                    end else if (fill_reg >= FW'(gbka_pkg::ENTRIES)) begin
                        ms_next = gbka_pkg::ST_FULL;
                    end else begin
                        ms_next   = gbka_pkg::ST_ADDED;
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[IW-1:0];
                        wr_data   = {tag_reg, key_reg, SW'(time_reg), CW'(1)};
                        fill_next = fill_reg + FW'(1);
                    end
                end
            end
            default: state_next = gbka_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(gbka_pkg::ENTRIES))
        else $error("fill count beyond table size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbka_pkg::S_DIV && dcnt_reg == KW'(1)) |=> state_reg == gbka_pkg::S_OUT)
        else $error("divider did not finish");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == gbka_pkg::S_CHECK || state_reg == gbka_pkg::S_DONE))
        else $error("table write outside update");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable({m_status, m_key_out, m_avg_time, m_last})))
        else $error("result word changed while waiting");
endmodule
